### rtl/core/project_nearest_keypoint_match_assert.svh
// Assertion macros shared by the keypoint matcher RTL.
// Depends on nothing; the including module supplies i_clk and i_rst_n.
`ifndef PROJECT_NEAREST_KEYPOINT_MATCH_ASSERT_SVH
`define PROJECT_NEAREST_KEYPOINT_MATCH_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define NKM_ASSERT_IMP(label, cond, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (expr)) \
        else $error("nkm assertion failed");

// Next-cycle implication, checked outside reset.
`define NKM_ASSERT_NXT(label, cond, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (expr)) \
        else $error("nkm assertion failed");

`endif

### rtl/core/nkm_pkg.sv
// Shared types and constants of the keypoint matcher.
// Depends on nothing.
`timescale 1ns / 1ps

package nkm_pkg;

    typedef enum logic [1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_APPEND = 2'd1,
        FUNC_POSE   = 2'd2,
        FUNC_QUERY  = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        REG_FOCAL_X       = 3'd0,
        REG_FOCAL_Y       = 3'd1,
        REG_CENTER_X      = 3'd2,
        REG_CENTER_Y      = 3'd3,
        REG_IMAGE_WIDTH   = 3'd4,
        REG_IMAGE_HEIGHT  = 3'd5,
        REG_SEARCH_RADIUS = 3'd6,
        REG_UNUSED        = 3'd7
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_TADD,
        ST_ZCHK,
        ST_PMUL,
        ST_DSTART,
        ST_DWAIT,
        ST_BOUND,
        ST_SCAN,
        ST_DONE
    } t_state;

    localparam logic [30:0] FOCAL_RESET    = 31'd34603008;
    localparam logic [30:0] CENTER_X_RESET = 31'd20971520;
    localparam logic [30:0] CENTER_Y_RESET = 31'd15728640;
    localparam logic [12:0] WIDTH_RESET    = 13'd640;
    localparam logic [12:0] HEIGHT_RESET   = 13'd480;
    localparam logic [7:0]  RADIUS_RESET   = 8'd5;
    localparam int          POSE_ENTRIES   = 12;
    localparam int          DIV_STEPS      = 64;

endpackage

### rtl/core/project_nearest_keypoint_match.sv
// Projective nearest-keypoint matcher. Words of func clear, append and pose are
// taken in the idle state without holding the input. A query word transforms the
// point by the pose with one shared multiplier, projects both axes through a
// serial divider that yields one quotient bit per cycle, then scans the keypoint
// store one entry per cycle through its single read port. A query with zero depth
// skips the projection and the scan, and one that lands outside the image skips
// the scan. Input stalls while a query is in flight; the result sits in an output
// register, so the next word can be taken while it waits.
// Depends on nkm_pkg, nkm_div, nkm_kp_mem and the assertion header.
`timescale 1ns / 1ps
`include "project_nearest_keypoint_match_assert.svh"

module project_nearest_keypoint_match #(
    parameter int MAX_KEYPOINTS = 1024,
    parameter int FRAC_BITS     = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_func,
    input  logic [3:0]         i_slot,
    input  logic signed [31:0] i_coord_a,
    input  logic signed [31:0] i_coord_b,
    input  logic signed [31:0] i_coord_c,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_match_found,
    output logic [9:0]         o_match_index,
    output logic               o_in_image,
    output logic               o_zero_depth,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int IW = (MAX_KEYPOINTS > 1) ? $clog2(MAX_KEYPOINTS) : 1;
    localparam int CW = $clog2(MAX_KEYPOINTS + 1);
    localparam int RW = 8 + FRAC_BITS;
    localparam int SW = 2 * RW;

    // Configuration registers.
    logic [30:0] r_fx, r_fy, r_cx, r_cy;
    logic [12:0] r_width, r_height;
    logic [7:0]  r_radius_px;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fx        <= nkm_pkg::FOCAL_RESET;
            r_fy        <= nkm_pkg::FOCAL_RESET;
            r_cx        <= nkm_pkg::CENTER_X_RESET;
            r_cy        <= nkm_pkg::CENTER_Y_RESET;
            r_width     <= nkm_pkg::WIDTH_RESET;
            r_height    <= nkm_pkg::HEIGHT_RESET;
            r_radius_px <= nkm_pkg::RADIUS_RESET;
        end else if (cfg_wr) begin
            case (nkm_pkg::t_reg_idx'(paddr[4:2]))
                nkm_pkg::REG_FOCAL_X:       r_fx        <= pwdata[30:0];
                nkm_pkg::REG_FOCAL_Y:       r_fy        <= pwdata[30:0];
                nkm_pkg::REG_CENTER_X:      r_cx        <= pwdata[30:0];
                nkm_pkg::REG_CENTER_Y:      r_cy        <= pwdata[30:0];
                nkm_pkg::REG_IMAGE_WIDTH:   r_width     <= pwdata[12:0];
                nkm_pkg::REG_IMAGE_HEIGHT:  r_height    <= pwdata[12:0];
                nkm_pkg::REG_SEARCH_RADIUS: r_radius_px <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (nkm_pkg::t_reg_idx'(paddr[4:2]))
            nkm_pkg::REG_FOCAL_X:       prdata = {1'b0, r_fx};
            nkm_pkg::REG_FOCAL_Y:       prdata = {1'b0, r_fy};
            nkm_pkg::REG_CENTER_X:      prdata = {1'b0, r_cx};
            nkm_pkg::REG_CENTER_Y:      prdata = {1'b0, r_cy};
            nkm_pkg::REG_IMAGE_WIDTH:   prdata = {19'd0, r_width};
            nkm_pkg::REG_IMAGE_HEIGHT:  prdata = {19'd0, r_height};
            nkm_pkg::REG_SEARCH_RADIUS: prdata = {24'd0, r_radius_px};
            default:                    prdata = '0;
        endcase
    end

    // Sequencer state and datapath registers.
    nkm_pkg::t_state r_state, n_state;
    logic               in_acc;
    logic [CW-1:0]      r_count;
    logic signed [31:0] r_pose [nkm_pkg::POSE_ENTRIES];
    logic signed [31:0] r_pt [3];
    logic signed [31:0] r_q [3];
    logic [1:0]         r_row, r_col;
    logic               r_axis;
    logic signed [65:0] r_prod, r_acc, r_u, r_v;
    logic [3:0]         pose_addr;
    logic signed [31:0] pose_rd;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] acc_sum, q_sum;
    logic               div_start, div_done;
    logic signed [63:0] div_quot;

    // Scan pipeline.
    logic [CW-1:0]      r_rd_addr;
    logic               rd_en, scan_end;
    logic signed [31:0] kp_x, kp_y;
    logic               r_v0, r_v1, r_v2;
    logic [IW-1:0]      r_idx0, r_idx1, r_idx2;
    logic               r_ok1, r_ok2;
    logic [RW-1:0]      r_dx, r_dy;
    logic [SW-1:0]      r_sx, r_sy, r_best;
    logic [RW-1:0]      radius;
    logic signed [66:0] dx_full, dy_full;
    logic [66:0]        dx_abs, dy_abs;
    logic [SW:0]        d_sum;
    logic signed [65:0] umax, vmax;
    logic               in_bounds;

    // Result registers.
    logic               r_res_zero, r_res_in, r_found;
    logic [IW-1:0]      r_best_idx;
    logic               r_out_valid;
    logic               r_o_found, r_o_in, r_o_zero;
    logic [31:0]        r_o_idx;

    assign in_acc = i_in_valid && !o_in_stall;
    assign radius = {r_radius_px, {FRAC_BITS{1'b0}}};

    // Pose has a single read port; translation is read in its own step.
    assign pose_addr = (r_state == nkm_pkg::ST_TADD) ? {r_row, 2'd3} : {r_row, r_col};
    assign pose_rd   = r_pose[pose_addr];

    always_comb begin
        if (r_state == nkm_pkg::ST_PMUL) begin
            mul_a = r_axis ? $signed({2'b00, r_fy}) : $signed({2'b00, r_fx});
            mul_b = r_axis ? 33'(r_q[1]) : 33'(r_q[0]);
        end else begin
            mul_a = 33'(pose_rd);
            mul_b = 33'(r_pt[r_col]);
        end
    end

    assign acc_sum = r_acc + (r_prod >>> FRAC_BITS);
    assign q_sum   = r_acc + 66'(pose_rd);

    assign umax = (66'($signed({1'b0, r_width}))  - 66'sd1) <<< FRAC_BITS;
    assign vmax = (66'($signed({1'b0, r_height})) - 66'sd1) <<< FRAC_BITS;
    assign in_bounds = (r_u >= 0) && (r_v >= 0) && (r_u <= umax) && (r_v <= vmax);

    assign scan_end = (r_rd_addr == r_count) && !r_v0 && !r_v1 && !r_v2;

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            nkm_pkg::ST_IDLE:
                if (in_acc && nkm_pkg::t_func'(i_func) == nkm_pkg::FUNC_QUERY) begin
                    n_state = nkm_pkg::ST_MUL;
                end
            nkm_pkg::ST_MUL:    n_state = nkm_pkg::ST_ACC;
            nkm_pkg::ST_ACC:
                n_state = (r_col == 2'd2) ? nkm_pkg::ST_TADD : nkm_pkg::ST_MUL;
            nkm_pkg::ST_TADD:
                n_state = (r_row == 2'd2) ? nkm_pkg::ST_ZCHK : nkm_pkg::ST_MUL;
            nkm_pkg::ST_ZCHK:
                n_state = (r_q[2] == 0) ? nkm_pkg::ST_DONE : nkm_pkg::ST_PMUL;
            nkm_pkg::ST_PMUL:   n_state = nkm_pkg::ST_DSTART;
            nkm_pkg::ST_DSTART: n_state = nkm_pkg::ST_DWAIT;
            nkm_pkg::ST_DWAIT:
                if (div_done) begin
                    n_state = r_axis ? nkm_pkg::ST_BOUND : nkm_pkg::ST_PMUL;
                end
            nkm_pkg::ST_BOUND:
                n_state = in_bounds ? nkm_pkg::ST_SCAN : nkm_pkg::ST_DONE;
            nkm_pkg::ST_SCAN:
                if (scan_end) begin
                    n_state = nkm_pkg::ST_DONE;
                end
            nkm_pkg::ST_DONE:
                if (!r_out_valid || !i_out_stall) begin
                    n_state = nkm_pkg::ST_IDLE;
                end
            default: n_state = nkm_pkg::ST_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        o_in_stall = (r_state != nkm_pkg::ST_IDLE);
        div_start  = (r_state == nkm_pkg::ST_DSTART);
        rd_en      = (r_state == nkm_pkg::ST_SCAN) && (r_rd_addr != r_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nkm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // List length and pose entries; the pose resets to identity rotation.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            for (int i = 0; i < nkm_pkg::POSE_ENTRIES; i++) begin
                r_pose[i] <= (i == 0 || i == 5 || i == 10) ? 32'(64'd1 << FRAC_BITS) : '0;
            end
        end else if (in_acc) begin
            case (nkm_pkg::t_func'(i_func))
                nkm_pkg::FUNC_CLEAR: r_count <= '0;
                nkm_pkg::FUNC_APPEND:
                    if (r_count < CW'(MAX_KEYPOINTS)) begin
                        r_count <= r_count + CW'(1);
                    end
                nkm_pkg::FUNC_POSE:
                    if (i_slot < 4'(nkm_pkg::POSE_ENTRIES)) begin
                        r_pose[i_slot] <= i_coord_a;
                    end
                default: ;
            endcase
        end
    end

    // Transform, projection and scan datapath.
    always_ff @(posedge i_clk) begin
        case (r_state)
            nkm_pkg::ST_IDLE: begin
                r_pt[0]    <= i_coord_a;
                r_pt[1]    <= i_coord_b;
                r_pt[2]    <= i_coord_c;
                r_row      <= 2'd0;
                r_col      <= 2'd0;
                r_acc      <= '0;
                r_axis     <= 1'b0;
                r_res_zero <= 1'b0;
                r_res_in   <= 1'b0;
                r_found    <= 1'b0;
                r_best_idx <= '0;
            end
            nkm_pkg::ST_MUL:  r_prod <= mul_a * mul_b;
            nkm_pkg::ST_ACC: begin
                r_acc <= acc_sum;
                r_col <= r_col + 2'd1;
            end
            nkm_pkg::ST_TADD: begin
                // Saturate the row sum to the signed 32 bit range.
                if (q_sum > 66'sh7FFF_FFFF) begin
                    r_q[r_row] <= 32'sh7FFF_FFFF;
                end else if (q_sum < -66'sh8000_0000) begin
                    r_q[r_row] <= -32'sh8000_0000;
                end else begin
                    r_q[r_row] <= q_sum[31:0];
                end
                r_acc <= '0;
                r_col <= 2'd0;
                r_row <= r_row + 2'd1;
            end
            nkm_pkg::ST_ZCHK: r_res_zero <= (r_q[2] == 0);
            nkm_pkg::ST_PMUL: r_prod <= mul_a * mul_b;
            nkm_pkg::ST_DWAIT:
                if (div_done) begin
                    if (r_axis) begin
                        r_v <= 66'(div_quot) + 66'($signed({1'b0, r_cy}));
                    end else begin
                        r_u <= 66'(div_quot) + 66'($signed({1'b0, r_cx}));
                    end
                    r_axis <= 1'b1;
                end
            nkm_pkg::ST_BOUND: begin
                r_res_in <= in_bounds;
                r_best   <= radius * radius;
            end
            nkm_pkg::ST_SCAN:
                if (r_v2 && r_ok2 && (d_sum < {1'b0, r_best})) begin
                    r_best     <= d_sum[SW-1:0];
                    r_best_idx <= r_idx2;
                    r_found    <= 1'b1;
                end
            default: ;
        endcase
    end

    // Scan pipeline: read, distance and range check, squares, compare.
    always_comb begin
        dx_full = 67'(kp_x) - 67'(r_u);
        dy_full = 67'(kp_y) - 67'(r_v);
        dx_abs  = dx_full[66] ? 67'(-dx_full) : 67'(dx_full);
        dy_abs  = dy_full[66] ? 67'(-dy_full) : 67'(dy_full);
        d_sum   = {1'b0, r_sx} + {1'b0, r_sy};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v0 <= rd_en;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == nkm_pkg::ST_BOUND) begin
            r_rd_addr <= '0;
        end else if (rd_en) begin
            r_rd_addr <= r_rd_addr + CW'(1);
        end
        r_idx0 <= r_rd_addr[IW-1:0];
        r_idx1 <= r_idx0;
        r_ok1  <= (dx_abs < 67'(radius)) && (dy_abs < 67'(radius));
        r_dx   <= dx_abs[RW-1:0];
        r_dy   <= dy_abs[RW-1:0];
        r_idx2 <= r_idx1;
        r_ok2  <= r_ok1;
        r_sx   <= r_dx * r_dx;
        r_sy   <= r_dy * r_dy;
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == nkm_pkg::ST_DONE && (!r_out_valid || !i_out_stall)) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == nkm_pkg::ST_DONE && (!r_out_valid || !i_out_stall)) begin
            r_o_zero  <= r_res_zero;
            r_o_in    <= r_res_in;
            r_o_found <= r_found;
            r_o_idx   <= r_found ? 32'(r_best_idx) : 32'd0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_match_found = r_o_found;
    assign o_match_index = r_o_idx[9:0];
    assign o_in_image    = r_o_in;
    assign o_zero_depth  = r_o_zero;

    nkm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_prod[63:0]),
        .i_den   (r_q[2]),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    nkm_kp_mem #(
        .DEPTH (MAX_KEYPOINTS),
        .AW    (IW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (in_acc && nkm_pkg::t_func'(i_func) == nkm_pkg::FUNC_APPEND
                    && r_count < CW'(MAX_KEYPOINTS)),
        .i_wr_addr (r_count[IW-1:0]),
        .i_wr_x    (i_coord_a),
        .i_wr_y    (i_coord_b),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rd_addr[IW-1:0]),
        .o_rd_x    (kp_x),
        .o_rd_y    (kp_y)
    );

    `NKM_ASSERT_IMP(a_zero_excl, o_out_valid && o_zero_depth, !o_in_image && !o_match_found)
    `NKM_ASSERT_IMP(a_found_in, o_out_valid && o_match_found, o_in_image)
    `NKM_ASSERT_IMP(a_count_max, 1'b1, r_count <= CW'(MAX_KEYPOINTS))
    `NKM_ASSERT_NXT(a_done_hold, r_state == nkm_pkg::ST_DONE && r_out_valid && i_out_stall,
                    r_state == nkm_pkg::ST_DONE)

endmodule

### rtl/core/nkm_div.sv
// Serial signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on nkm_pkg.
`timescale 1ns / 1ps

module nkm_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_num,
    input  logic signed [31:0] i_den,
    output logic               o_done,
    output logic signed [63:0] o_quot
);

    logic        r_busy;
    logic [6:0]  r_cnt;
    logic [63:0] r_n;
    logic [31:0] r_rem;
    logic [31:0] r_d;
    logic        r_neg;
    logic        r_done;
    logic [32:0] n_trial;
    logic        n_bit;

    always_comb begin
        n_trial = {r_rem, r_n[63]};
        n_bit   = (n_trial >= {1'b0, r_d});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'(nkm_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= i_num[63] ? 64'(-i_num) : i_num;
            r_d   <= i_den[31] ? 32'(-i_den) : i_den;
            r_neg <= i_num[63] ^ i_den[31];
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= n_bit ? 32'(n_trial - {1'b0, r_d}) : n_trial[31:0];
            r_n   <= {r_n[62:0], n_bit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed(r_n) : $signed(r_n);

endmodule

### rtl/core/nkm_kp_mem.sv
// Keypoint position store: one write port, one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module nkm_kp_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic signed [31:0] i_wr_x,
    input  logic signed [31:0] i_wr_y,
    input  logic              i_rd_en,
    input  logic [AW-1:0]     i_rd_addr,
    output logic signed [31:0] o_rd_x,
    output logic signed [31:0] o_rd_y
);

    logic [63:0] r_mem [DEPTH];
    logic [63:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_x, i_wr_y};
        end
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_x = $signed(r_rd[63:32]);
    assign o_rd_y = $signed(r_rd[31:0]);

endmodule

### dv/tb_top.sv
// Self-checking testbench for the projective nearest-keypoint matcher.
// Depends on nkm_pkg and the project_nearest_keypoint_match RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int  KP_DEPTH   = 1024;
    localparam int  FRAC       = 16;
    localparam int  SETTLE     = 60;
    localparam int  LONG_LIST  = 230;
    localparam longint LIMIT   = 3000000;
    localparam longint ONE     = 64'sd65536;

    // One input word as the driver presents it.
    typedef struct {
        nkm_pkg::t_func     func;
        logic [3:0]         slot;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
    } t_word;

    // One match result.
    typedef struct {
        bit       found;
        bit [9:0] index;
        bit       in_img;
        bit       zdepth;
    } t_match;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [1:0]         i_func = '0;
    logic [3:0]         i_slot = '0;
    logic signed [31:0] i_coord_a = '0;
    logic signed [31:0] i_coord_b = '0;
    logic signed [31:0] i_coord_c = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic               o_match_found;
    logic [9:0]         o_match_index;
    logic               o_in_image;
    logic               o_zero_depth;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [4:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    project_nearest_keypoint_match dut (.*);

    // Clock with a 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mirror of the block's state, used to work out every expected match.
    logic signed [31:0] kp_col [KP_DEPTH];
    logic signed [31:0] kp_row [KP_DEPTH];
    int                 kp_count;
    logic signed [31:0] pose [nkm_pkg::POSE_ENTRIES];
    logic [30:0]        fx, fy, cx, cy;
    logic [12:0]        img_w, img_h;
    logic [7:0]         radius_px;

    t_word  pending_words [$];
    t_match expected_matches [$];
    int     mismatches = 0;
    longint cycles = 0;
    bit     calm = 1'b0;   // when set, neither side idles
    bit     in_fire = 1'b0;

    // Prints one line per mismatch and counts it.
    task automatic report(input string what, input longint got, input longint want);
        mismatches++;
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    endtask

    // One row of [R|t] applied to the point: each product floored, sum saturated.
    function automatic longint pose_row(input int r, input longint px, input longint py,
                                        input longint pz);
        longint s;
        s = ((longint'(pose[r*4]) * px) >>> FRAC)
          + ((longint'(pose[r*4+1]) * py) >>> FRAC)
          + ((longint'(pose[r*4+2]) * pz) >>> FRAC)
          + longint'(pose[r*4+3]);
        if (s > 64'sd2147483647) s = 64'sd2147483647;
        if (s < -64'sd2147483648) s = -64'sd2147483648;
        return s;
    endfunction

    // Applies one accepted word to the mirror; a query leaves its match in the store.
    task automatic apply_word(input t_word w);
        longint qx, qy, qz, u, v, umax, vmax, rad, best, dx, dy, sx, sy;
        t_match m;
        m = '{found: 0, index: 0, in_img: 0, zdepth: 0};
        case (w.func)
            nkm_pkg::FUNC_CLEAR: kp_count = 0;
            nkm_pkg::FUNC_APPEND: begin
                // An append to a full list is dropped.
                if (kp_count < KP_DEPTH) begin
                    kp_col[kp_count] = w.a;
                    kp_row[kp_count] = w.b;
                    kp_count++;
                end
            end
            nkm_pkg::FUNC_POSE: begin
                if (w.slot < nkm_pkg::POSE_ENTRIES) pose[w.slot] = w.a;
            end
            default: begin
                qx = pose_row(0, w.a, w.b, w.c);
                qy = pose_row(1, w.a, w.b, w.c);
                qz = pose_row(2, w.a, w.b, w.c);
                if (qz == 0) begin
                    m.zdepth = 1'b1;
                end else begin
                    u = (longint'(fx) * qx) / qz + longint'(cx);
                    v = (longint'(fy) * qy) / qz + longint'(cy);
                    umax = (longint'(img_w) - 1) * ONE;
                    vmax = (longint'(img_h) - 1) * ONE;
                    if (u >= 0 && v >= 0 && u <= umax && v <= vmax) begin
                        m.in_img = 1'b1;
                        rad = longint'(radius_px) * ONE;
                        best = rad * rad;
                        for (int i = 0; i < kp_count; i++) begin
                            dx = longint'(kp_col[i]) - u;
                            dy = longint'(kp_row[i]) - v;
                            if (dx < 0) dx = -dx;
                            if (dy < 0) dy = -dy;
                            if (dx >= rad || dy >= rad) continue;
                            sx = dx * dx;
                            sy = dy * dy;
                            // Strictly less, so the earliest of equal distances stays.
                            if (sx + sy >= best) continue;
                            best = sx + sy;
                            m.found = 1'b1;
                            m.index = i[9:0];
                        end
                    end
                end
                expected_matches.insert(expected_matches.size(), m);
            end
        endcase
    endtask

    // Monitor: takes accepted words into the mirror and checks accepted results.
    always @(posedge i_clk) begin
        t_match want;
        cycles++;
        in_fire = i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_matches.size() == 0) begin
                report("unexpected result", 0, 0);
            end else begin
                want = expected_matches.pop_front();
                if (o_match_found !== want.found) report("match_found", o_match_found, want.found);
                if (o_match_index !== want.index) report("match_index", o_match_index, want.index);
                if (o_in_image !== want.in_img) report("in_image", o_in_image, want.in_img);
                if (o_zero_depth !== want.zdepth) report("zero_depth", o_zero_depth, want.zdepth);
            end
        end
        if (in_fire) begin
            apply_word('{func: nkm_pkg::t_func'(i_func), slot: i_slot, a: i_coord_a,
                         b: i_coord_b, c: i_coord_c});
        end
        if (cycles > LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Driver: presents the next pending word once the current one has gone, idling at random.
    always @(negedge i_clk) begin
        t_word w;
        if (i_rst_n) begin
            i_out_stall <= !calm && ($urandom_range(0, 99) < 20);
            if (!i_in_valid || in_fire) begin
                if (pending_words.size() != 0 && (calm || $urandom_range(0, 99) >= 20)) begin
                    w = pending_words.pop_front();
                    i_in_valid <= 1'b1;
                    i_func     <= w.func;
                    i_slot     <= w.slot;
                    i_coord_a  <= w.a;
                    i_coord_b  <= w.b;
                    i_coord_c  <= w.c;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic push_word(input nkm_pkg::t_func f, input logic [3:0] s, input longint a,
                             input longint b, input longint c);
        pending_words.insert(pending_words.size(),
                             '{func: f, slot: s, a: a[31:0], b: b[31:0], c: c[31:0]});
    endtask

    // Waits until every word has gone in and every match has come out, then lets the block settle.
    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_words.size() != 0 || i_in_valid || expected_matches.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic reg_write(input nkm_pkg::t_reg_idx idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            nkm_pkg::REG_FOCAL_X:       fx = value[30:0];
            nkm_pkg::REG_FOCAL_Y:       fy = value[30:0];
            nkm_pkg::REG_CENTER_X:      cx = value[30:0];
            nkm_pkg::REG_CENTER_Y:      cy = value[30:0];
            nkm_pkg::REG_IMAGE_WIDTH:   img_w = value[12:0];
            nkm_pkg::REG_IMAGE_HEIGHT:  img_h = value[12:0];
            nkm_pkg::REG_SEARCH_RADIUS: radius_px = value[7:0];
            default: ;
        endcase
    endtask

    task automatic set_camera(input logic [31:0] f_x, input logic [31:0] f_y,
                              input logic [31:0] c_x, input logic [31:0] c_y,
                              input logic [31:0] w, input logic [31:0] h,
                              input logic [31:0] r);
        reg_write(nkm_pkg::REG_FOCAL_X, f_x);
        reg_write(nkm_pkg::REG_FOCAL_Y, f_y);
        reg_write(nkm_pkg::REG_CENTER_X, c_x);
        reg_write(nkm_pkg::REG_CENTER_Y, c_y);
        reg_write(nkm_pkg::REG_IMAGE_WIDTH, w);
        reg_write(nkm_pkg::REG_IMAGE_HEIGHT, h);
        reg_write(nkm_pkg::REG_SEARCH_RADIUS, r);
    endtask

    task automatic pose_identity();
        for (int i = 0; i < nkm_pkg::POSE_ENTRIES; i++)
            push_word(nkm_pkg::FUNC_POSE, i[3:0], (i % 5 == 0) ? ONE : 0, $urandom, $urandom);
    endtask

    function automatic longint spread(input longint span);
        return longint'($urandom_range(0, 2 * span)) - span;
    endfunction

    // Mostly well-formed traffic near the principal point, with some raw noise words.
    task automatic random_words(input int n);
        int r;
        longint z;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 6) begin
                push_word(nkm_pkg::FUNC_CLEAR, $urandom, $urandom, $urandom, $urandom);
            end else if (r < 40) begin
                push_word(nkm_pkg::FUNC_APPEND, $urandom, longint'(cx) + spread(10 * ONE),
                          longint'(cy) + spread(10 * ONE), $urandom);
            end else if (r < 45) begin
                r = $urandom_range(0, 15);
                if (r < nkm_pkg::POSE_ENTRIES && r % 5 == 0)
                    push_word(nkm_pkg::FUNC_POSE, r[3:0], ONE + spread(ONE / 64), 0, 0);
                else
                    push_word(nkm_pkg::FUNC_POSE, r[3:0], spread(ONE / 128), $urandom,
                              $urandom);
            end else if (r < 90) begin
                z = $urandom_range(ONE / 2, 4 * ONE);
                push_word(nkm_pkg::FUNC_QUERY, $urandom, spread(z / 40), spread(z / 40), z);
            end else begin
                push_word(nkm_pkg::t_func'($urandom_range(0, 3)), $urandom, $urandom,
                          $urandom, $urandom);
            end
        end
    endtask

    initial begin
        // Mirror starts at the reset state.
        kp_count = 0;
        foreach (pose[i]) pose[i] = (i % 5 == 0) ? 32'sd65536 : 32'sd0;
        fx = nkm_pkg::FOCAL_RESET;
        fy = nkm_pkg::FOCAL_RESET;
        cx = nkm_pkg::CENTER_X_RESET;
        cy = nkm_pkg::CENTER_Y_RESET;
        img_w = nkm_pkg::WIDTH_RESET;
        img_h = nkm_pkg::HEIGHT_RESET;
        radius_px = nkm_pkg::RADIUS_RESET;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (5) @(negedge i_clk);

        // Directed words on the reset camera.
        push_word(nkm_pkg::FUNC_QUERY, 0, 0, 0, ONE);                 // empty list
        push_word(nkm_pkg::FUNC_APPEND, 0, 320 * ONE, 240 * ONE, 0);  // dead centre
        push_word(nkm_pkg::FUNC_APPEND, 0, 320 * ONE, 240 * ONE, 0);  // tie with the first
        push_word(nkm_pkg::FUNC_APPEND, 0, 322 * ONE, 241 * ONE, 0);
        push_word(nkm_pkg::FUNC_APPEND, 0, -64'sd2147483648, 64'sd2147483647, 0);
        push_word(nkm_pkg::FUNC_QUERY, 0, 0, 0, ONE);                 // tie, earliest wins
        push_word(nkm_pkg::FUNC_QUERY, 0, ONE / 264, ONE / 528, ONE); // nearer the third
        push_word(nkm_pkg::FUNC_QUERY, 0, 5, 7, 0);                   // zero depth
        push_word(nkm_pkg::FUNC_QUERY, 0, 0, 0, -ONE);                // negative depth
        push_word(nkm_pkg::FUNC_QUERY, 0, ONE, 0, ONE);               // right of the image
        push_word(nkm_pkg::FUNC_QUERY, 0, 64'sd2147483647, 64'sd2147483647,
                  64'sd2147483647);
        push_word(nkm_pkg::FUNC_QUERY, 0, -64'sd2147483648, -64'sd2147483648,
                  -64'sd2147483648);
        push_word(nkm_pkg::FUNC_POSE, 4'd15, 64'sd12345, 0, 0);       // beyond the last slot
        push_word(nkm_pkg::FUNC_POSE, 4'd12, -1, 0, 0);
        push_word(nkm_pkg::FUNC_POSE, 4'd0, 64'sd2147483647, 0, 0);   // saturating transform
        push_word(nkm_pkg::FUNC_POSE, 4'd3, 64'sd2147483647, 0, 0);
        push_word(nkm_pkg::FUNC_QUERY, 0, 64'sd2147483647, 0, ONE);
        push_word(nkm_pkg::FUNC_POSE, 4'd11, -ONE, 0, 0);             // translation cancels depth
        push_word(nkm_pkg::FUNC_QUERY, 0, 0, 0, ONE);
        push_word(nkm_pkg::FUNC_CLEAR, 0, 0, 0, 0);
        push_word(nkm_pkg::FUNC_QUERY, 0, 0, 0, ONE);
        pose_identity();
        wait_drained();

        // Reset camera written back explicitly, large radius, no idling on either side.
        calm = 1'b1;
        set_camera({1'b0, nkm_pkg::FOCAL_RESET}, {1'b0, nkm_pkg::FOCAL_RESET},
                   {1'b0, nkm_pkg::CENTER_X_RESET}, {1'b0, nkm_pkg::CENTER_Y_RESET},
                   640, 480, 255);
        random_words(60);
        wait_drained();
        calm = 1'b0;

        // Extremes of the intrinsics, zero radius.
        set_camera(32'h7FFF_FFFF, 0, 0, 32'h7FFF_FFFF, 4096, 4096, 0);
        pose_identity();
        random_words(40);
        wait_drained();

        // A small camera with a moderate radius.
        set_camera(32'(300 * ONE), 32'(300 * ONE), 32'(100 * ONE), 32'(80 * ONE),
                   200, 160, 8);
        pose_identity();
        random_words(60);
        wait_drained();

        // One-pixel image: only a projection onto the origin lies inside.
        set_camera(32'(528 * ONE), 32'(528 * ONE), 0, 0, 1, 1, 1);
        pose_identity();
        push_word(nkm_pkg::FUNC_APPEND, 0, 0, 0, 0);
        push_word(nkm_pkg::FUNC_QUERY, 0, 0, 0, ONE);
        random_words(30);
        wait_drained();

        // Zero-sized image is empty.
        set_camera(32'(528 * ONE), 32'(528 * ONE), 0, 0, 0, 0, 5);
        random_words(20);
        wait_drained();

        // A long list, then a few long scans.
        set_camera({1'b0, nkm_pkg::FOCAL_RESET}, {1'b0, nkm_pkg::FOCAL_RESET},
                   {1'b0, nkm_pkg::CENTER_X_RESET}, {1'b0, nkm_pkg::CENTER_Y_RESET},
                   640, 480, 5);
        pose_identity();
        push_word(nkm_pkg::FUNC_CLEAR, 0, 0, 0, 0);
        for (int i = 0; i < LONG_LIST; i++)
            push_word(nkm_pkg::FUNC_APPEND, 0, 64'sd20971520 + spread(6 * ONE),
                      64'sd15728640 + spread(6 * ONE), 0);
        for (int i = 0; i < 6; i++)
            push_word(nkm_pkg::FUNC_QUERY, 0, spread(ONE / 100), spread(ONE / 100), ONE);
        push_word(nkm_pkg::FUNC_CLEAR, 0, 0, 0, 0);
        random_words(40);
        wait_drained();

        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/nkm_pkg.sv
rtl/core/nkm_div.sv
rtl/core/nkm_kp_mem.sv
rtl/core/project_nearest_keypoint_match.sv
dv/tb_top.sv
